@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// pre holds -> post holds in the same cycle
`define ASSERT_IMPLIES(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);
// pre holds -> post holds in the next cycle
`define ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rstn, pre, post, msg)
`define ASSERT_NEXT(label, clk, rstn, pre, post, msg)
`endif

`endif

@@ rtl/core/hntt_pkg.sv @@
// ----------------------------------------------------------------------------
// hntt_pkg
// Types and constants of the hashed noise terrain tile generator.
// ----------------------------------------------------------------------------
package hntt_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SEED_KEY       = 3'd0,
        CFG_MAP_WIDTH      = 3'd1,
        CFG_MAP_HEIGHT     = 3'd2,
        CFG_ALGORITHM_MODE = 3'd3,
        CFG_FEATURE_FLAGS  = 3'd4,
        CFG_WATER_LEVEL    = 3'd5,
        CFG_MOUNTAIN_LEVEL = 3'd6,
        CFG_FOREST_DENSITY = 3'd7
    } cfg_index_t;

    // terrain classes
    typedef enum logic [2:0] {
        CLS_DEEP_WATER = 3'd0,
        CLS_WATER      = 3'd1,
        CLS_SAND       = 3'd2,
        CLS_MOUNTAIN   = 3'd3,
        CLS_FOREST     = 3'd4,
        CLS_GRASS      = 3'd5
    } terrain_class_t;

    // splitmix64 finalizer and coordinate hashing
    localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL1     = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL2     = 64'h94d049bb133111eb;
    localparam logic [63:0] HASH_MUL_X   = 64'h9e3779b185ebca87;
    localparam logic [63:0] HASH_MUL_Y   = 64'hc2b2ae3d27d4eb4f;
    localparam logic [63:0] SALT_COARSE  = 64'h000000005f3759df;
    localparam logic [63:0] SALT_FINE    = 64'h0000000085ebca6b;
    localparam logic [63:0] SALT_FOREST  = 64'h0000000027d4eb2f;

    // Q16 falloff and weights
    localparam logic [16:0] ONE_Q16        = 17'd65536;
    localparam logic [15:0] FALLOFF_SLOPE  = 16'd53740;
    localparam logic [15:0] W_FALL_ISLAND  = 16'd57672;
    localparam logic [15:0] W_FINE_ISLAND  = 16'd7864;
    localparam logic [15:0] W_FALL_LAYER   = 16'd36700;
    localparam logic [15:0] W_COARSE_LAYER = 16'd19661;
    localparam logic [15:0] W_FINE_LAYER   = 16'd9175;

    // level scale and classification bands
    localparam logic [13:0] LEVEL_MAX   = 14'd10000;
    localparam logic [15:0] DEEP_BAND   = 16'd800;
    localparam logic [15:0] SAND_BAND   = 16'd400;
    localparam logic [15:0] FOREST_BAND = 16'd800;

    // move costs
    localparam logic [7:0] COST_WATER    = 8'd255;
    localparam logic [7:0] COST_MOUNTAIN = 8'd8;
    localparam logic [7:0] COST_FOREST   = 8'd4;
    localparam logic [7:0] COST_OPEN     = 8'd2;

    // register reset values
    localparam logic [12:0] RST_MAP_WIDTH      = 13'd64;
    localparam logic [12:0] RST_MAP_HEIGHT     = 13'd64;
    localparam logic [1:0]  RST_FEATURE_FLAGS  = 2'd3;
    localparam logic [13:0] RST_WATER_LEVEL    = 14'd3500;
    localparam logic [13:0] RST_MOUNTAIN_LEVEL = 14'd7500;
    localparam logic [13:0] RST_FOREST_DENSITY = 14'd4000;

endpackage

@@ rtl/core/hashed_noise_terrain_tile.sv @@
// ----------------------------------------------------------------------------
// hashed_noise_terrain_tile
// Generates height, terrain class, blocking and move cost for one tile.
//
// Input stream s_*: one tile coordinate pair per item. Output stream m_*: one
// result item per input item, in order. The user must write registers through
// the cfg_* port only while no item is in flight; the block does not enforce
// this, and writes take effect at once. The pipeline takes one item per cycle
// while the output is not stalled. The depth is set by the pipelined divider
// (four quotient bits a stage) and the pipelined square root (two root bits a
// stage) of the island falloff; the three splitmix64 hash lanes run beside
// them in eight stages.
// Reset empties the pipeline and loads the register defaults. While m_tvalid
// is high and m_tready low, every stage holds and s_tready is low, so no item
// is lost or repeated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hashed_noise_terrain_tile
    import hntt_pkg::*;
#(
    parameter int COORD_BITS          = 12,
    parameter int NOISE_FRACTION_BITS = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // configuration write port
    input  logic                                    cfg_wr_en,
    input  logic [2:0]                              cfg_addr,
    input  logic [63:0]                             cfg_wr_data,
    // input items: tile_x, tile_y
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]       s_tdata,
    // result items: tile_level, terrain_class, blocked, move_cost
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [31:0]                             m_tdata
);

    localparam int CB  = COORD_BITS;
    localparam int NFB = NOISE_FRACTION_BITS;
    // divider: quotient width and stages
    localparam int NW  = CB + 17;
    localparam int DS  = (NW + 3) / 4;
    localparam int DP  = DS * 4;
    // square root: root width, stages, register widths
    localparam int RW  = NW + 1;
    localparam int SS  = (RW + 1) / 2;
    localparam int RT  = 2 * SS;
    localparam int SQP = 4 * SS;
    localparam int RMS = RT + 3;
    // stage numbers
    localparam int ST_NOISE = 8;
    localparam int ST_ABS   = DS + 1;
    localparam int ST_RAD   = DS + 3;
    localparam int ST_ROOT  = ST_RAD + SS;
    localparam int ST_FALL  = ST_ROOT + 2;
    localparam int ST_OUT   = ST_FALL + 5;

    // ------------------------------------------------------------------
    // configuration registers
    logic [63:0] seed_key_reg;
    logic [12:0] map_width_reg;
    logic [12:0] map_height_reg;
    logic        mode_reg;
    logic [1:0]  flags_reg;
    logic [13:0] water_reg;
    logic [13:0] mountain_reg;
    logic [13:0] forest_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_key_reg   <= '0;
            map_width_reg  <= RST_MAP_WIDTH;
            map_height_reg <= RST_MAP_HEIGHT;
            mode_reg       <= 1'b0;
            flags_reg      <= RST_FEATURE_FLAGS;
            water_reg      <= RST_WATER_LEVEL;
            mountain_reg   <= RST_MOUNTAIN_LEVEL;
            forest_reg     <= RST_FOREST_DENSITY;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_addr))
                CFG_SEED_KEY:       seed_key_reg   <= cfg_wr_data;
                CFG_MAP_WIDTH:      map_width_reg  <= cfg_wr_data[12:0];
                CFG_MAP_HEIGHT:     map_height_reg <= cfg_wr_data[12:0];
                CFG_ALGORITHM_MODE: mode_reg       <= cfg_wr_data[0];
                CFG_FEATURE_FLAGS:  flags_reg      <= cfg_wr_data[1:0];
                CFG_WATER_LEVEL:    water_reg      <= cfg_wr_data[13:0];
                CFG_MOUNTAIN_LEVEL: mountain_reg   <= cfg_wr_data[13:0];
                CFG_FOREST_DENSITY: forest_reg     <= cfg_wr_data[13:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: every stage advances unless the output is stalled
    logic [ST_OUT:0] vld_reg;
    logic            adv;

    assign adv      = ~vld_reg[ST_OUT] | m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[ST_OUT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[ST_OUT-1:0], s_tvalid};
        end
    end

    // capture coordinates
    logic [CB-1:0] x_reg;
    logic [CB-1:0] y_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg <= s_tdata[CB-1:0];
            y_reg <= s_tdata[2*CB-1:CB];
        end
    end

    // ------------------------------------------------------------------
    // centering divider, lane 0 for x / width, lane 1 for y / height
    logic [12:0]   div_den [2];
    logic [CB-1:0] div_coord [2];
    logic [DP-1:0] dnum_reg  [2][1:DS];
    logic [DP-1:0] dnum_next [2][1:DS];
    logic [DP-1:0] dq_reg    [2][1:DS];
    logic [DP-1:0] dq_next   [2][1:DS];
    logic [13:0]   drem_reg  [2][1:DS];
    logic [13:0]   drem_next [2][1:DS];

    assign div_den[0]   = (map_width_reg == '0) ? 13'd1 : map_width_reg;
    assign div_den[1]   = (map_height_reg == '0) ? 13'd1 : map_height_reg;
    assign div_coord[0] = x_reg;
    assign div_coord[1] = y_reg;

    // four restoring steps a stage
    always_comb begin
        logic [DP-1:0] num;
        logic [DP-1:0] q;
        logic [13:0]   rem;
        for (int k = 0; k < 2; k++) begin
            for (int s = 1; s <= DS; s++) begin
                if (s == 1) begin
                    num = DP'({div_coord[k], 1'b1, 16'h0000});
                    q   = '0;
                    rem = '0;
                end else begin
                    num = dnum_reg[k][s-1];
                    q   = dq_reg[k][s-1];
                    rem = drem_reg[k][s-1];
                end
                for (int j = 0; j < 4; j++) begin
                    rem = {rem[12:0], num[DP-1]};
                    num = {num[DP-2:0], 1'b0};
                    if (rem >= {1'b0, div_den[k]}) begin
                        rem = rem - {1'b0, div_den[k]};
                        q   = {q[DP-2:0], 1'b1};
                    end else begin
                        q   = {q[DP-2:0], 1'b0};
                    end
                end
                dnum_next[k][s] = num;
                dq_next[k][s]   = q;
                drem_next[k][s] = rem;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 2; k++) begin
                for (int s = 1; s <= DS; s++) begin
                    dnum_reg[k][s] <= dnum_next[k][s];
                    dq_reg[k][s]   <= dq_next[k][s];
                    drem_reg[k][s] <= drem_next[k][s];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // distance from the center: magnitudes, squares, radicand
    logic [NW-1:0]   ax_reg [2];
    logic [2*NW-1:0] sq_reg [2];
    logic [SQP-1:0]  rad_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 2; k++) begin
                if (dq_reg[k][DS][NW-1:0] >= NW'(ONE_Q16)) begin
                    ax_reg[k] <= dq_reg[k][DS][NW-1:0] - NW'(ONE_Q16);
                end else begin
                    ax_reg[k] <= NW'(ONE_Q16) - dq_reg[k][DS][NW-1:0];
                end
                sq_reg[k] <= (2*NW)'(ax_reg[k]) * (2*NW)'(ax_reg[k]);
            end
            rad_reg <= SQP'(sq_reg[0]) + SQP'(sq_reg[1]);
        end
    end

    // ------------------------------------------------------------------
    // integer square root, two root bits a stage
    logic [SQP-1:0] srad_reg   [1:SS];
    logic [SQP-1:0] srad_next  [1:SS];
    logic [RMS-1:0] srem_reg   [1:SS];
    logic [RMS-1:0] srem_next  [1:SS];
    logic [RT-1:0]  sroot_reg  [1:SS];
    logic [RT-1:0]  sroot_next [1:SS];

    always_comb begin
        logic [SQP-1:0] rad;
        logic [RMS-1:0] rem;
        logic [RMS-1:0] trial;
        logic [RT-1:0]  root;
        for (int s = 1; s <= SS; s++) begin
            if (s == 1) begin
                rad  = rad_reg;
                rem  = '0;
                root = '0;
            end else begin
                rad  = srad_reg[s-1];
                rem  = srem_reg[s-1];
                root = sroot_reg[s-1];
            end
            for (int j = 0; j < 2; j++) begin
                rem   = {rem[RMS-3:0], rad[SQP-1:SQP-2]};
                rad   = {rad[SQP-3:0], 2'b00};
                trial = RMS'({root, 2'b01});
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = {root[RT-2:0], 1'b1};
                end else begin
                    root = {root[RT-2:0], 1'b0};
                end
            end
            srad_next[s]  = rad;
            srem_next[s]  = rem;
            sroot_next[s] = root;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int s = 1; s <= SS; s++) begin
                srad_reg[s]  <= srad_next[s];
                srem_reg[s]  <= srem_next[s];
                sroot_reg[s] <= sroot_next[s];
            end
        end
    end

    // ------------------------------------------------------------------
    // falloff: drop = round(root * slope), saturate at zero
    logic [RW+15:0] drop_prod_reg;
    logic [16:0]    fall_reg;
    logic [RW+16:0] drop_sum;
    logic [RW:0]    drop;

    assign drop_sum = (RW+17)'(drop_prod_reg) + (RW+17)'(32768);
    assign drop     = drop_sum[RW+16:16];

    always_ff @(posedge aclk) begin
        if (adv) begin
            drop_prod_reg <= (RW+16)'(sroot_reg[SS][RW-1:0]) * (RW+16)'(FALLOFF_SLOPE);
            if (drop >= (RW+1)'(ONE_Q16)) begin
                fall_reg <= '0;
            end else begin
                fall_reg <= ONE_Q16 - drop[16:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // hash lanes: 0 coarse at (x/4, y/4), 1 fine, 2 forest
    logic [CB-1:0]  hx [3];
    logic [CB-1:0]  hy [3];
    logic [63:0]    salt [3];
    logic [CB+31:0] pxl_reg [3], pxl_next [3];
    logic [31:0]    pxh_reg [3], pxh_next [3];
    logic [CB+31:0] pyl_reg [3], pyl_next [3];
    logic [31:0]    pyh_reg [3], pyh_next [3];
    logic [63:0]    key_reg [3], key_next [3];
    logic [63:0]    v_reg   [3], v_next   [3];
    logic [63:0]    a_ll_reg [3], a_ll_next [3];
    logic [31:0]    a_lh_reg [3], a_lh_next [3];
    logic [31:0]    a_hl_reg [3], a_hl_next [3];
    logic [63:0]    w_reg   [3], w_next   [3];
    logic [63:0]    b_ll_reg [3], b_ll_next [3];
    logic [31:0]    b_lh_reg [3], b_lh_next [3];
    logic [31:0]    b_hl_reg [3], b_hl_next [3];
    logic [63:0]    z_reg   [3], z_next   [3];
    logic [NFB-1:0] noise_reg [3], noise_next [3];

    assign hx[0]   = x_reg >> 2;
    assign hy[0]   = y_reg >> 2;
    assign hx[1]   = x_reg;
    assign hy[1]   = y_reg;
    assign hx[2]   = x_reg;
    assign hy[2]   = y_reg;
    assign salt[0] = SALT_COARSE;
    assign salt[1] = SALT_FINE;
    assign salt[2] = SALT_FOREST;

    always_comb begin
        logic [CB+31:0] phi_x;
        logic [CB+31:0] phi_y;
        logic [63:0]    t1;
        logic [63:0]    t2;
        logic [63:0]    h;
        for (int l = 0; l < 3; l++) begin
            // coordinate products, 64-bit low half from two 32-bit slices
            pxl_next[l] = (CB+32)'(hx[l]) * (CB+32)'(HASH_MUL_X[31:0]);
            phi_x       = (CB+32)'(hx[l]) * (CB+32)'(HASH_MUL_X[63:32]);
            pxh_next[l] = phi_x[31:0];
            pyl_next[l] = (CB+32)'(hy[l]) * (CB+32)'(HASH_MUL_Y[31:0]);
            phi_y       = (CB+32)'(hy[l]) * (CB+32)'(HASH_MUL_Y[63:32]);
            pyh_next[l] = phi_y[31:0];
            // hash key
            key_next[l] = seed_key_reg
                        ^ (64'(pxl_reg[l]) + {pxh_reg[l], 32'h0})
                        ^ (64'(pyl_reg[l]) + {pyh_reg[l], 32'h0})
                        ^ salt[l];
            v_next[l]   = key_reg[l] + GOLDEN_GAMMA;
            // first finalizer multiply
            t1           = v_reg[l] ^ (v_reg[l] >> 30);
            a_ll_next[l] = 64'(t1[31:0]) * 64'(MIX_MUL1[31:0]);
            a_lh_next[l] = t1[31:0] * MIX_MUL1[63:32];
            a_hl_next[l] = t1[63:32] * MIX_MUL1[31:0];
            w_next[l]    = a_ll_reg[l] + {a_lh_reg[l] + a_hl_reg[l], 32'h0};
            // second finalizer multiply
            t2           = w_reg[l] ^ (w_reg[l] >> 27);
            b_ll_next[l] = 64'(t2[31:0]) * 64'(MIX_MUL2[31:0]);
            b_lh_next[l] = t2[31:0] * MIX_MUL2[63:32];
            b_hl_next[l] = t2[63:32] * MIX_MUL2[31:0];
            z_next[l]    = b_ll_reg[l] + {b_lh_reg[l] + b_hl_reg[l], 32'h0};
            // keep the top fraction bits
            h             = z_reg[l] ^ (z_reg[l] >> 31);
            noise_next[l] = h[63 -: NFB];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < 3; l++) begin
                pxl_reg[l]   <= pxl_next[l];
                pxh_reg[l]   <= pxh_next[l];
                pyl_reg[l]   <= pyl_next[l];
                pyh_reg[l]   <= pyh_next[l];
                key_reg[l]   <= key_next[l];
                v_reg[l]     <= v_next[l];
                a_ll_reg[l]  <= a_ll_next[l];
                a_lh_reg[l]  <= a_lh_next[l];
                a_hl_reg[l]  <= a_hl_next[l];
                w_reg[l]     <= w_next[l];
                b_ll_reg[l]  <= b_ll_next[l];
                b_lh_reg[l]  <= b_lh_next[l];
                b_hl_reg[l]  <= b_hl_next[l];
                z_reg[l]     <= z_next[l];
                noise_reg[l] <= noise_next[l];
            end
        end
    end

    // bring coarse and fine noise to Q16
    logic [15:0] coarse_q16;
    logic [15:0] fine_q16;

    if (NFB >= 16) begin : g_q16_trunc
        assign coarse_q16 = noise_reg[0][NFB-1 -: 16];
        assign fine_q16   = noise_reg[1][NFB-1 -: 16];
    end else begin : g_q16_pad
        assign coarse_q16 = {noise_reg[0], {(16-NFB){1'b0}}};
        assign fine_q16   = {noise_reg[1], {(16-NFB){1'b0}}};
    end

    // delay noise until the falloff is ready
    logic [15:0]    ncoarse_reg [ST_NOISE+1:ST_FALL];
    logic [15:0]    nfine_reg   [ST_NOISE+1:ST_FALL];
    logic [NFB-1:0] nforest_reg [ST_NOISE+1:ST_FALL];

    always_ff @(posedge aclk) begin
        if (adv) begin
            ncoarse_reg[ST_NOISE+1] <= coarse_q16;
            nfine_reg[ST_NOISE+1]   <= fine_q16;
            nforest_reg[ST_NOISE+1] <= noise_reg[2];
            for (int i = ST_NOISE + 2; i <= ST_FALL; i++) begin
                ncoarse_reg[i] <= ncoarse_reg[i-1];
                nfine_reg[i]   <= nfine_reg[i-1];
                nforest_reg[i] <= nforest_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // weighting, scaling and rounding of the level
    logic [32:0]     wp0_reg;
    logic [31:0]     wp1_reg;
    logic [31:0]     wp2_reg;
    logic [NFB+13:0] forest_prod_reg;
    logic [33:0]     wsum_reg;
    logic            fok_sum_reg;
    logic [47:0]     scale_reg;
    logic            fok_scale_reg;
    logic [13:0]     lvl_reg;
    logic            fok_lvl_reg;
    logic [13:0]     forest_sat;
    logic [48:0]     lvl_round;

    assign forest_sat = (forest_reg > LEVEL_MAX) ? LEVEL_MAX : forest_reg;
    assign lvl_round  = 49'(scale_reg) + 49'(64'h80000000);

    always_ff @(posedge aclk) begin
        if (adv) begin
            // products
            if (mode_reg) begin
                wp0_reg <= 33'(fall_reg) * 33'(W_FALL_ISLAND);
                wp1_reg <= 32'(nfine_reg[ST_FALL]) * 32'(W_FINE_ISLAND);
                wp2_reg <= '0;
            end else begin
                wp0_reg <= 33'(fall_reg) * 33'(W_FALL_LAYER);
                wp1_reg <= 32'(ncoarse_reg[ST_FALL]) * 32'(W_COARSE_LAYER);
                wp2_reg <= 32'(nfine_reg[ST_FALL]) * 32'(W_FINE_LAYER);
            end
            forest_prod_reg <= (NFB+14)'(nforest_reg[ST_FALL]) * (NFB+14)'(LEVEL_MAX);
            // sum and forest compare
            wsum_reg    <= 34'(wp0_reg) + 34'(wp1_reg) + 34'(wp2_reg);
            fok_sum_reg <= forest_prod_reg < {forest_sat, {NFB{1'b0}}};
            // scale to 1/10000
            scale_reg     <= 48'(wsum_reg) * 48'(LEVEL_MAX);
            fok_scale_reg <= fok_sum_reg;
            // round and clamp
            if (lvl_round[48:32] > 17'(LEVEL_MAX)) begin
                lvl_reg <= LEVEL_MAX;
            end else begin
                lvl_reg <= lvl_round[45:32];
            end
            fok_lvl_reg <= fok_scale_reg;
        end
    end

    // ------------------------------------------------------------------
    // classification into the output register
    logic signed [15:0] lvl_s;
    logic signed [15:0] wl_s;
    logic signed [15:0] ml_s;
    terrain_class_t     cls;
    logic [7:0]         cost;
    terrain_class_t     out_class_reg;
    logic [13:0]        out_level_reg;
    logic               out_blocked_reg;
    logic [7:0]         out_cost_reg;

    assign lvl_s = signed'({2'b00, lvl_reg});
    assign wl_s  = signed'({2'b00, (water_reg > LEVEL_MAX) ? LEVEL_MAX : water_reg});
    assign ml_s  = signed'({2'b00, (mountain_reg > LEVEL_MAX) ? LEVEL_MAX : mountain_reg});

    always_comb begin
        if (lvl_s < wl_s - signed'(DEEP_BAND)) begin
            cls = CLS_DEEP_WATER;
        end else if (lvl_s < wl_s) begin
            cls = CLS_WATER;
        end else if (lvl_s < wl_s + signed'(SAND_BAND)) begin
            cls = CLS_SAND;
        end else if (flags_reg[0] && lvl_s >= ml_s) begin
            cls = CLS_MOUNTAIN;
        end else if (flags_reg[1] && lvl_s > wl_s + signed'(FOREST_BAND) && fok_lvl_reg) begin
            cls = CLS_FOREST;
        end else begin
            cls = CLS_GRASS;
        end
        case (cls)
            CLS_DEEP_WATER, CLS_WATER: cost = COST_WATER;
            CLS_MOUNTAIN:              cost = COST_MOUNTAIN;
            CLS_FOREST:                cost = COST_FOREST;
            default:                   cost = COST_OPEN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_level_reg   <= lvl_reg;
            out_class_reg   <= cls;
            out_blocked_reg <= (cls == CLS_DEEP_WATER) || (cls == CLS_WATER);
            out_cost_reg    <= cost;
        end
    end

    assign m_tdata = {6'b000000, out_cost_reg, out_blocked_reg, out_class_reg, out_level_reg};

    // ------------------------------------------------------------------
    // assertions
    `ASSERT_IMPLIES(a_stall_blocks_input, aclk, aresetn, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")
    `ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_tvalid && s_tready, vld_reg[0], "accepted item did not enter the pipeline")
    `ASSERT_IMPLIES(a_level_range, aclk, aresetn, m_tvalid, out_level_reg <= LEVEL_MAX, "level above 10000")
    `ASSERT_IMPLIES(a_blocked_class, aclk, aresetn, m_tvalid, out_blocked_reg == ((out_class_reg == CLS_DEEP_WATER) || (out_class_reg == CLS_WATER)), "blocked flag disagrees with class")

endmodule
